/* sv/tpo_pkg.sv */
// Package with the widths, number types and helper functions of the triangle pair overlap test.
package tpo_pkg;

	localparam int COORD_BITS = 16;
	localparam int DIFF_W     = COORD_BITS + 1;
	localparam int PROD_W     = 2 * DIFF_W;
	localparam int SUM_W      = PROD_W + 1;
	localparam int NC_W       = SUM_W + 2;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [DIFF_W-1:0]     diff_t;
	typedef logic signed [PROD_W-1:0]     prod_t;
	typedef logic signed [SUM_W-1:0]      sum_t;
	typedef logic signed [NC_W-1:0]       wide_t;

	function automatic coord_t min3(input coord_t a, input coord_t b, input coord_t c);
		coord_t m;
		m = (a < b) ? a : b;
		return (m < c) ? m : c;
	endfunction

	function automatic coord_t max3(input coord_t a, input coord_t b, input coord_t c);
		coord_t m;
		m = (a > b) ? a : b;
		return (m > c) ? m : c;
	endfunction

	// True when num / den lies in [0, 1], bounds included; den is nonzero.
	function automatic logic in_unit(input sum_t num, input sum_t den);
		logic r;
		if (den > 0) begin
			r = (num >= 0) && (num <= den);
		end else begin
			r = (num <= 0) && (num >= den);
		end
		return r;
	endfunction

endpackage

/* sv/triangle_pair_overlap_test_top.sv */
// Top level of the pipelined triangle pair overlap test.
// Five register stages; a transaction passes stages one to four and then sits in the output
// register, stage five, which holds it while out_stall is high.
// Throughput: one transaction per cycle when out_stall is low; the product stage holds one
// 17 by 17 multiplier for each of the 66 cross-product terms, so nothing is shared.
// Each stage advances when it is empty or the stage after it advances, so bubbles close up.
// Reset clears the stage valid bits only; the block accepts transactions right after reset.
module triangle_pair_overlap_test_top
	import tpo_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [15:0] first_v0_x,
	input  logic [15:0] first_v0_y,
	input  logic [15:0] first_v1_x,
	input  logic [15:0] first_v1_y,
	input  logic [15:0] first_v2_x,
	input  logic [15:0] first_v2_y,
	input  logic [15:0] second_v0_x,
	input  logic [15:0] second_v0_y,
	input  logic [15:0] second_v1_x,
	input  logic [15:0] second_v1_y,
	input  logic [15:0] second_v2_x,
	input  logic [15:0] second_v2_y,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        overlap
);

	coord_t fx [3];
	coord_t fy [3];
	coord_t gx [3];
	coord_t gy [3];
	coord_t tx [2][3];
	coord_t ty [2][3];
	coord_t px [2];
	coord_t py [2];

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic en1, en2, en3, en4, en5;

	diff_t  e1x_s1 [3];
	diff_t  e1y_s1 [3];
	diff_t  e2x_s1 [3];
	diff_t  e2y_s1 [3];
	diff_t  offx_s1 [3][3];
	diff_t  offy_s1 [3][3];
	diff_t  tu_s1 [2];
	diff_t  tv_s1 [2];
	diff_t  tw_s1 [2];
	diff_t  tz_s1 [2];
	diff_t  tq_s1 [2];
	diff_t  tpx_s1 [2];
	diff_t  tpy_s1 [2];
	coord_t fminx_s1, fmaxx_s1, fminy_s1, fmaxy_s1;
	coord_t gminx_s1, gmaxx_s1, gminy_s1, gmaxy_s1;

	prod_t  pd1_s2 [3][3];
	prod_t  pd2_s2 [3][3];
	prod_t  pa1_s2 [3][3];
	prod_t  pa2_s2 [3][3];
	prod_t  pb1_s2 [3][3];
	prod_t  pb2_s2 [3][3];
	prod_t  td1_s2 [2];
	prod_t  td2_s2 [2];
	prod_t  ta1_s2 [2];
	prod_t  ta2_s2 [2];
	prod_t  tb1_s2 [2];
	prod_t  tb2_s2 [2];
	logic   box_ok_s2;

	sum_t   sden_s3 [3][3];
	sum_t   sna_s3 [3][3];
	sum_t   snb_s3 [3][3];
	sum_t   tden_s3 [2];
	sum_t   tna_s3 [2];
	sum_t   tnb_s3 [2];
	logic   box_ok_s3;

	logic   seg_hit_s4;
	logic   tnz_s4 [2];
	wide_t  tden_s4 [2];
	wide_t  tna_s4 [2];
	wide_t  tnb_s4 [2];
	wide_t  tnc_s4 [2];
	logic   box_ok_s4;

	logic   overlap_s5;

	logic   seg_hit;
	logic   tri_hit;
	sum_t   nden [2];
	sum_t   nna [2];
	sum_t   nnb [2];

	// Coordinates are the low COORD_BITS bits of each field, read as signed.
	always_comb begin
		fx[0] = coord_t'(first_v0_x[COORD_BITS-1:0]);
		fy[0] = coord_t'(first_v0_y[COORD_BITS-1:0]);
		fx[1] = coord_t'(first_v1_x[COORD_BITS-1:0]);
		fy[1] = coord_t'(first_v1_y[COORD_BITS-1:0]);
		fx[2] = coord_t'(first_v2_x[COORD_BITS-1:0]);
		fy[2] = coord_t'(first_v2_y[COORD_BITS-1:0]);
		gx[0] = coord_t'(second_v0_x[COORD_BITS-1:0]);
		gy[0] = coord_t'(second_v0_y[COORD_BITS-1:0]);
		gx[1] = coord_t'(second_v1_x[COORD_BITS-1:0]);
		gy[1] = coord_t'(second_v1_y[COORD_BITS-1:0]);
		gx[2] = coord_t'(second_v2_x[COORD_BITS-1:0]);
		gy[2] = coord_t'(second_v2_y[COORD_BITS-1:0]);
		// The first containment test puts the first vertex of the first triangle in the
		// second triangle, the other one does the reverse.
		for (int v = 0; v < 3; v++) begin
			tx[0][v] = gx[v];
			ty[0][v] = gy[v];
			tx[1][v] = fx[v];
			ty[1][v] = fy[v];
		end
		px[0] = fx[0];
		py[0] = fy[0];
		px[1] = gx[0];
		py[1] = gy[0];
	end

	assign en5      = !valid_s5 || !out_stall;
	assign en4      = !valid_s4 || en5;
	assign en3      = !valid_s3 || en4;
	assign en2      = !valid_s2 || en3;
	assign en1      = !valid_s1 || en2;
	assign in_stall = !en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (en1) begin
				valid_s1 <= in_valid;
			end
			if (en2) begin
				valid_s2 <= valid_s1;
			end
			if (en3) begin
				valid_s3 <= valid_s2;
			end
			if (en4) begin
				valid_s4 <= valid_s3;
			end
			if (en5) begin
				valid_s5 <= valid_s4;
			end
		end
	end

	// Stage 1: edge vectors, offsets and bounding boxes.
	always_ff @(posedge clk) begin
		if (en1) begin
			for (int i = 0; i < 3; i++) begin
				e1x_s1[i] <= diff_t'(fx[(i == 2) ? 0 : i + 1]) - diff_t'(fx[i]);
				e1y_s1[i] <= diff_t'(fy[(i == 2) ? 0 : i + 1]) - diff_t'(fy[i]);
				e2x_s1[i] <= diff_t'(gx[(i == 2) ? 0 : i + 1]) - diff_t'(gx[i]);
				e2y_s1[i] <= diff_t'(gy[(i == 2) ? 0 : i + 1]) - diff_t'(gy[i]);
				for (int j = 0; j < 3; j++) begin
					offx_s1[i][j] <= diff_t'(fx[i]) - diff_t'(gx[j]);
					offy_s1[i][j] <= diff_t'(fy[i]) - diff_t'(gy[j]);
				end
			end
			for (int k = 0; k < 2; k++) begin
				tu_s1[k]  <= diff_t'(ty[k][1]) - diff_t'(ty[k][2]);
				tv_s1[k]  <= diff_t'(tx[k][2]) - diff_t'(tx[k][1]);
				tw_s1[k]  <= diff_t'(ty[k][2]) - diff_t'(ty[k][0]);
				tz_s1[k]  <= diff_t'(tx[k][0]) - diff_t'(tx[k][2]);
				tq_s1[k]  <= diff_t'(ty[k][0]) - diff_t'(ty[k][2]);
				tpx_s1[k] <= diff_t'(px[k]) - diff_t'(tx[k][2]);
				tpy_s1[k] <= diff_t'(py[k]) - diff_t'(ty[k][2]);
			end
			fminx_s1 <= min3(fx[0], fx[1], fx[2]);
			fmaxx_s1 <= max3(fx[0], fx[1], fx[2]);
			fminy_s1 <= min3(fy[0], fy[1], fy[2]);
			fmaxy_s1 <= max3(fy[0], fy[1], fy[2]);
			gminx_s1 <= min3(gx[0], gx[1], gx[2]);
			gmaxx_s1 <= max3(gx[0], gx[1], gx[2]);
			gminy_s1 <= min3(gy[0], gy[1], gy[2]);
			gmaxy_s1 <= max3(gy[0], gy[1], gy[2]);
		end
	end

	// Stage 2: all cross-product terms and the box rejection.
	always_ff @(posedge clk) begin
		if (en2) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					pd1_s2[i][j] <= prod_t'(e2y_s1[j]) * prod_t'(e1x_s1[i]);
					pd2_s2[i][j] <= prod_t'(e2x_s1[j]) * prod_t'(e1y_s1[i]);
					pa1_s2[i][j] <= prod_t'(e2x_s1[j]) * prod_t'(offy_s1[i][j]);
					pa2_s2[i][j] <= prod_t'(e2y_s1[j]) * prod_t'(offx_s1[i][j]);
					pb1_s2[i][j] <= prod_t'(e1x_s1[i]) * prod_t'(offy_s1[i][j]);
					pb2_s2[i][j] <= prod_t'(e1y_s1[i]) * prod_t'(offx_s1[i][j]);
				end
			end
			for (int k = 0; k < 2; k++) begin
				td1_s2[k] <= prod_t'(tu_s1[k]) * prod_t'(tz_s1[k]);
				td2_s2[k] <= prod_t'(tv_s1[k]) * prod_t'(tq_s1[k]);
				ta1_s2[k] <= prod_t'(tu_s1[k]) * prod_t'(tpx_s1[k]);
				ta2_s2[k] <= prod_t'(tv_s1[k]) * prod_t'(tpy_s1[k]);
				tb1_s2[k] <= prod_t'(tw_s1[k]) * prod_t'(tpx_s1[k]);
				tb2_s2[k] <= prod_t'(tz_s1[k]) * prod_t'(tpy_s1[k]);
			end
			box_ok_s2 <= !((fminx_s1 > gmaxx_s1) || (gminx_s1 > fmaxx_s1) ||
				(fminy_s1 > gmaxy_s1) || (gminy_s1 > fmaxy_s1));
		end
	end

	// Stage 3: denominators and numerators.
	always_ff @(posedge clk) begin
		if (en3) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					sden_s3[i][j] <= sum_t'(pd1_s2[i][j]) - sum_t'(pd2_s2[i][j]);
					sna_s3[i][j]  <= sum_t'(pa1_s2[i][j]) - sum_t'(pa2_s2[i][j]);
					snb_s3[i][j]  <= sum_t'(pb1_s2[i][j]) - sum_t'(pb2_s2[i][j]);
				end
			end
			for (int k = 0; k < 2; k++) begin
				tden_s3[k] <= sum_t'(td1_s2[k]) + sum_t'(td2_s2[k]);
				tna_s3[k]  <= sum_t'(ta1_s2[k]) + sum_t'(ta2_s2[k]);
				tnb_s3[k]  <= sum_t'(tb1_s2[k]) + sum_t'(tb2_s2[k]);
			end
			box_ok_s3 <= box_ok_s2;
		end
	end

	always_comb begin
		seg_hit = 1'b0;
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				if ((sden_s3[i][j] != 0) && in_unit(sna_s3[i][j], sden_s3[i][j]) &&
					in_unit(snb_s3[i][j], sden_s3[i][j])) begin
					seg_hit = 1'b1;
				end
			end
		end
		for (int k = 0; k < 2; k++) begin
			if (tden_s3[k] < 0) begin
				nden[k] = -tden_s3[k];
				nna[k]  = -tna_s3[k];
				nnb[k]  = -tnb_s3[k];
			end else begin
				nden[k] = tden_s3[k];
				nna[k]  = tna_s3[k];
				nnb[k]  = tnb_s3[k];
			end
		end
	end

	// Stage 4: segment verdicts, and the barycentric weights brought to a non-negative denominator.
	always_ff @(posedge clk) begin
		if (en4) begin
			seg_hit_s4 <= seg_hit;
			for (int k = 0; k < 2; k++) begin
				tnz_s4[k]  <= (tden_s3[k] != 0);
				tden_s4[k] <= wide_t'(nden[k]);
				tna_s4[k]  <= wide_t'(nna[k]);
				tnb_s4[k]  <= wide_t'(nnb[k]);
				tnc_s4[k]  <= wide_t'(nden[k]) - wide_t'(nna[k]) - wide_t'(nnb[k]);
			end
			box_ok_s4 <= box_ok_s3;
		end
	end

	always_comb begin
		tri_hit = 1'b0;
		for (int k = 0; k < 2; k++) begin
			if (tnz_s4[k] && (tna_s4[k] >= 0) && (tna_s4[k] <= tden_s4[k]) &&
				(tnb_s4[k] >= 0) && (tnb_s4[k] <= tden_s4[k]) &&
				(tnc_s4[k] >= 0) && (tnc_s4[k] <= tden_s4[k])) begin
				tri_hit = 1'b1;
			end
		end
	end

	// Stage 5: output register.
	always_ff @(posedge clk) begin
		if (en5) begin
			overlap_s5 <= box_ok_s4 && (seg_hit_s4 || tri_hit);
		end
	end

	assign out_valid = valid_s5;
	assign overlap   = overlap_s5;

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2 && valid_s3 && valid_s4 && valid_s5 && out_stall))
		else $error("Input stalled while the pipeline has an empty stage.");

	a_bubble_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s4 && !valid_s5) |=> valid_s5)
		else $error("A transaction in stage four did not move into an empty output register.");

	a_box_reject: assert property (@(posedge clk) disable iff (!arst_n)
		(en5 && valid_s4 && !box_ok_s4) |=> (valid_s5 && !overlap))
		else $error("A transaction rejected by the box test reported an overlap.");

	a_stage_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && en2) |=> valid_s2)
		else $error("A transaction was lost between stage one and stage two.");

endmodule

/* sim/triangle_pair_overlap_test_top_test.sv */
// Testbench for the triangle pair overlap test, with directed and random pairs.
`timescale 1ns / 100ps

module triangle_pair_overlap_test_top_test
	import tpo_pkg::*;
();

	localparam int HOLD_CYCLES    = 80;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int DRAIN_CYCLES   = 10;

	// Index 0 is first_v0_x, index 11 is second_v2_y.
	typedef logic [11:0][COORD_BITS-1:0] tri_pair_t;

	typedef struct {
		tri_pair_t pair;
		bit        typed;
		bit        value;
	} stim_row_t;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      in_valid  = 1'b0;
	logic      in_stall;
	logic      out_valid;
	logic      out_stall = 1'b0;
	logic      overlap;
	tri_pair_t pair_drv  = '0;
	bit        typed_drv = 1'b0;
	bit        typed_val = 1'b0;

	bit        overlap_q[$];
	stim_row_t dir_tab[$];
	int        accepted_in    = 0;
	int        checked        = 0;
	int        overlap_hits   = 0;
	int        fail_count     = 0;
	int        quiet_cycles   = 0;
	int        send_idle_pct  = 0;
	int        recv_stall_pct = 0;
	int        hold_left      = 0;

	always #1 clk = ~clk;

	triangle_pair_overlap_test_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.first_v0_x (pair_drv[0]),
		.first_v0_y (pair_drv[1]),
		.first_v1_x (pair_drv[2]),
		.first_v1_y (pair_drv[3]),
		.first_v2_x (pair_drv[4]),
		.first_v2_y (pair_drv[5]),
		.second_v0_x(pair_drv[6]),
		.second_v0_y(pair_drv[7]),
		.second_v1_x(pair_drv[8]),
		.second_v1_y(pair_drv[9]),
		.second_v2_x(pair_drv[10]),
		.second_v2_y(pair_drv[11]),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.overlap    (overlap)
	);

	function automatic longint to_long(input logic [COORD_BITS-1:0] raw);
		return longint'($signed(raw));
	endfunction

	function automatic bit ratio_in_unit(input longint num, input longint den);
		if (den > 0) begin
			return (num >= 0) && (num <= den);
		end
		return (num <= 0) && (num >= den);
	endfunction

	function automatic bit edges_meet(input longint ax, input longint ay, input longint bx,
			input longint by, input longint cx, input longint cy, input longint dx,
			input longint dy);
		longint ex1, ey1, ex2, ey2, ox, oy, den;
		ex1 = bx - ax;
		ey1 = by - ay;
		ex2 = dx - cx;
		ey2 = dy - cy;
		ox  = ax - cx;
		oy  = ay - cy;
		den = ey2 * ex1 - ex2 * ey1;
		if (den == 0) begin
			return 1'b0;
		end
		return ratio_in_unit(ex2 * oy - ey2 * ox, den) &&
			ratio_in_unit(ex1 * oy - ey1 * ox, den);
	endfunction

	function automatic bit tri_contains(input longint t0x, input longint t0y, input longint t1x,
			input longint t1y, input longint t2x, input longint t2y, input longint px,
			input longint py);
		longint den, wa, wb, wc;
		den = (t1y - t2y) * (t0x - t2x) + (t2x - t1x) * (t0y - t2y);
		wa  = (t1y - t2y) * (px - t2x) + (t2x - t1x) * (py - t2y);
		wb  = (t2y - t0y) * (px - t2x) + (t0x - t2x) * (py - t2y);
		if (den == 0) begin
			return 1'b0;
		end
		if (den < 0) begin
			den = -den;
			wa  = -wa;
			wb  = -wb;
		end
		wc = den - wa - wb;
		return wa >= 0 && wa <= den && wb >= 0 && wb <= den && wc >= 0 && wc <= den;
	endfunction

	function automatic bit predict_overlap(input tri_pair_t p);
		longint fx[3], fy[3], sx[3], sy[3];
		longint fx_lo, fx_hi, fy_lo, fy_hi, sx_lo, sx_hi, sy_lo, sy_hi;
		for (int k = 0; k < 3; k++) begin
			fx[k] = to_long(p[2 * k]);
			fy[k] = to_long(p[2 * k + 1]);
			sx[k] = to_long(p[6 + 2 * k]);
			sy[k] = to_long(p[7 + 2 * k]);
		end
		fx_lo = fx[0]; fx_hi = fx[0]; fy_lo = fy[0]; fy_hi = fy[0];
		sx_lo = sx[0]; sx_hi = sx[0]; sy_lo = sy[0]; sy_hi = sy[0];
		for (int k = 1; k < 3; k++) begin
			if (fx[k] < fx_lo) fx_lo = fx[k];
			if (fx[k] > fx_hi) fx_hi = fx[k];
			if (fy[k] < fy_lo) fy_lo = fy[k];
			if (fy[k] > fy_hi) fy_hi = fy[k];
			if (sx[k] < sx_lo) sx_lo = sx[k];
			if (sx[k] > sx_hi) sx_hi = sx[k];
			if (sy[k] < sy_lo) sy_lo = sy[k];
			if (sy[k] > sy_hi) sy_hi = sy[k];
		end
		if (fx_lo > sx_hi || sx_lo > fx_hi || fy_lo > sy_hi || sy_lo > fy_hi) begin
			return 1'b0;
		end
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				if (edges_meet(fx[i], fy[i], fx[(i + 1) % 3], fy[(i + 1) % 3],
						sx[j], sy[j], sx[(j + 1) % 3], sy[(j + 1) % 3])) begin
					return 1'b1;
				end
			end
		end
		if (tri_contains(sx[0], sy[0], sx[1], sy[1], sx[2], sy[2], fx[0], fy[0])) begin
			return 1'b1;
		end
		return tri_contains(fx[0], fy[0], fx[1], fy[1], fx[2], fy[2], sx[0], sy[0]);
	endfunction

	function automatic logic [COORD_BITS-1:0] near(input logic [COORD_BITS-1:0] base,
			input int span);
		return base + COORD_BITS'(int'($urandom_range(2 * span)) - span);
	endfunction

	// Random pair generator: mostly clustered shapes so that touching, collinear, nested and
	// degenerate configurations come up often, with a share of fully random coordinates.
	function automatic tri_pair_t make_pair();
		tri_pair_t               p;
		logic [COORD_BITS-1:0]   cx, cy, gx, gy, dx, dy;
		logic [COORD_BITS-1:0]   ext[7];
		int                      kind, span, m;
		ext  = '{16'h8000, 16'h8001, 16'hFFFF, 16'h0000, 16'h0001, 16'h7FFE, 16'h7FFF};
		kind = $urandom_range(99);
		cx   = COORD_BITS'($urandom);
		cy   = COORD_BITS'($urandom);
		if (kind < 25) begin
			for (int k = 0; k < 12; k++) p[k] = COORD_BITS'($urandom);
		end else if (kind < 50) begin
			span = $urandom_range(1, 12);
			for (int k = 0; k < 12; k++) p[k] = near((k % 2) ? cy : cx, span);
		end else if (kind < 65) begin
			for (int k = 0; k < 6; k++) begin
				p[k] = COORD_BITS'(int'($urandom_range(40000)) - 20000);
			end
			gx = COORD_BITS'((to_long(p[0]) + to_long(p[2]) + to_long(p[4])) / 3);
			gy = COORD_BITS'((to_long(p[1]) + to_long(p[3]) + to_long(p[5])) / 3);
			for (int k = 6; k < 12; k++) p[k] = near((k % 2) ? gy : gx, 3);
		end else if (kind < 75) begin
			dx = COORD_BITS'(int'($urandom_range(100)) - 50);
			dy = COORD_BITS'(int'($urandom_range(100)) - 50);
			for (int k = 0; k < 3; k++) begin
				m = $urandom_range(2);
				p[2 * k]     = cx + COORD_BITS'(m) * dx;
				p[2 * k + 1] = cy + COORD_BITS'(m) * dy;
			end
			for (int k = 6; k < 12; k++) p[k] = near((k % 2) ? cy : cx, 60);
		end else if (kind < 85) begin
			for (int k = 0; k < 12; k++) p[k] = ext[$urandom_range(6)];
		end else begin
			for (int k = 0; k < 6; k++) p[k] = near((k % 2) ? cy : cx, 40);
			for (int k = 0; k < 3; k++) begin
				m = $urandom_range(2);
				if ($urandom_range(1)) begin
					p[6 + 2 * k] = p[2 * m];
					p[7 + 2 * k] = p[2 * m + 1];
				end else begin
					p[6 + 2 * k] = near(cx, 40);
					p[7 + 2 * k] = near(cy, 40);
				end
			end
		end
		if ($urandom_range(1)) begin
			p = {p[5:0], p[11:6]};
		end
		return p;
	endfunction

	task automatic add_row(input int c[12], input bit typed, input bit value);
		stim_row_t r;
		for (int k = 0; k < 12; k++) r.pair[k] = COORD_BITS'(c[k]);
		r.typed = typed;
		r.value = value;
		dir_tab.push_back(r);
	endtask

	task automatic send_pair(input tri_pair_t p, input bit typed, input bit value);
		int seen;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid  <= 1'b1;
		pair_drv  <= p;
		typed_drv <= typed;
		typed_val <= value;
		seen = accepted_in;
		do @(negedge clk); while (accepted_in == seen);
	endtask

	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else begin
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	always @(posedge clk) begin : monitor
		bit moved;
		bit want;
		if (arst_n) begin
			moved = 1'b0;
			if (in_valid && !in_stall) begin
				overlap_q.push_back(typed_drv ? typed_val : predict_overlap(pair_drv));
				accepted_in++;
				moved = 1'b1;
			end
			if (out_valid && !out_stall) begin
				moved = 1'b1;
				if (overlap_q.size() == 0) begin
					$error("overlap: result with no transaction pending, actual %0d", overlap);
					fail_count++;
				end else begin
					want = overlap_q.pop_front();
					checked++;
					if (want) overlap_hits++;
					if (overlap !== want) begin
						$error("overlap: expected %0d, actual %0d", want, overlap);
						fail_count++;
					end
				end
			end
			quiet_cycles = moved ? 0 : quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Timeout: no transaction moved for %0d cycles", WATCHDOG_LIMIT);
				$display("Mismatches found");
				$finish;
			end
		end
	end

	initial begin
		add_row('{-32768, -32768, -32768, -32767, -32767, -32768,
			32767, 32767, 32766, 32767, 32767, 32766}, 1'b1, 1'b0);
		add_row('{-32768, -32768, 32767, -32768, -32768, 32767,
			-32768, -32768, 32767, -32768, -32768, 32767}, 1'b1, 1'b1);
		add_row('{-32768, -32768, -32768, -32768, -32768, -32768,
			-32768, -32768, -32768, -32768, -32768, -32768}, 1'b1, 1'b0);
		add_row('{32767, 32767, 32767, 32767, 32767, 32767,
			32767, 32767, 32767, 32767, 32767, 32767}, 1'b1, 1'b0);
		add_row('{0, 0, 10, 0, 0, 10, 0, 20, 10, 20, 0, 30}, 1'b1, 1'b0);
		add_row('{0, 20, 10, 20, 0, 30, 0, 0, 10, 0, 0, 10}, 1'b1, 1'b0);
		add_row('{0, 0, 10, 0, 0, 10, 20, 0, 30, 0, 20, 10}, 1'b1, 1'b0);
		add_row('{20, 0, 30, 0, 20, 10, 0, 0, 10, 0, 0, 10}, 1'b1, 1'b0);
		add_row('{0, 0, 10, 0, 0, 10, 10, 10, 20, 10, 10, 20}, 1'b0, 1'b0);
		add_row('{0, 0, 10, 0, 0, 10, 10, 0, 20, 0, 20, 10}, 1'b0, 1'b0);
		add_row('{0, 0, 10, 0, 5, 0, 2, 0, 8, 0, 20, 0}, 1'b0, 1'b0);
		add_row('{-100, -100, 100, -100, 0, 100, -1, -1, 1, -1, 0, 1}, 1'b0, 1'b0);
		add_row('{-1, -1, 1, -1, 0, 1, -100, -100, 100, -100, 0, 100}, 1'b0, 1'b0);
		add_row('{0, 0, 0, 0, 0, 0, -10, 0, 10, 0, 0, 10}, 1'b0, 1'b0);
		add_row('{-10, -10, 10, -10, 0, 10, 0, 0, 0, 0, 0, 0}, 1'b0, 1'b0);
		add_row('{-100, -100, 0, 100, 100, -100, 5, 5, 6, 5, 5, 6}, 1'b0, 1'b0);
		add_row('{-32768, -32768, 32767, 32767, -32768, 32767,
			32767, -32768, -32768, 32767, 32767, 32767}, 1'b0, 1'b0);
		add_row('{0, 0, 10, 0, 0, 10, -5, 5, 15, 5, 5, -5}, 1'b0, 1'b0);
		add_row('{0, 0, 10, 0, 5, 5, 2, 0, 8, 0, 5, -5}, 1'b0, 1'b0);
		add_row('{32767, 32767, 32767, -32768, -32768, 32767,
			32767, 32767, 32767, 32767, 32767, 32767}, 1'b0, 1'b0);
		add_row('{-1, -1, 0, 0, 1, -1, -1, 0, 0, -1, 1, 0}, 1'b0, 1'b0);

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct  = (ph == 0) ? 7 : (ph == 1) ? 79 : 0;
			recv_stall_pct = (ph == 0) ? 79 : (ph == 1) ? 7 : 0;
			if (ph == 0) begin
				foreach (dir_tab[r]) begin
					send_pair(dir_tab[r].pair, dir_tab[r].typed, dir_tab[r].value);
				end
			end
			if (ph == 2) begin
				hold_left = HOLD_CYCLES;
			end
			repeat ((ph == 2) ? 570 : 580) send_pair(make_pair(), 1'b0, 1'b0);
			in_valid <= 1'b0;
			do @(negedge clk); while (overlap_q.size() != 0);
		end
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("Checked %0d results (%0d overlapping) from directed and random triangle pairs.",
			checked, overlap_hits);
		$display("Pacing covered sparse and heavy stalls on both sides, a long output hold-off "
			, "and full-rate streaming.");
		if (fail_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
